// ===== rtl/ptlm_pkg.sv =====
// Package for the price-time level matcher: constants, codes and record types.
// Used by every module in the rtl folder; depends on nothing.
package ptlm_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;
   localparam int MAX_FILLS   = 63;
   localparam int FILL_W      = $clog2(MAX_FILLS + 1);

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_SWEEP = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      KIND_FILL   = 3'd0,
      KIND_DONE   = 3'd1,
      KIND_SELF   = 3'd2,
      KIND_LIMIT  = 3'd3,
      KIND_REJECT = 3'd4
   } kind_type;

   typedef enum logic [0:0] {
      ST_IDLE  = 1'b0,
      ST_SWEEP = 1'b1
   } state_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] account;
      logic [63:0] order_id;
      logic [31:0] remaining_qty;
      logic [31:0] visible_qty;
      logic [31:0] display_qty;
      logic [31:0] available_qty;
   } req_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic [31:0] account;
      logic [63:0] id;
      logic [31:0] remaining;
      logic [31:0] visible;
      logic [31:0] display;
   } entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [63:0] fill_order_id;
      logic [31:0] fill_account;
      logic [31:0] price;
      logic [31:0] quantity;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/price_time_level_matcher_unit.sv =====
// Plans the fills of one aggressor against up to 16 resting orders of one price
// level, in price-time order. The sweep engine takes an item only while the
// output queue has room; a sweep emits one result item (fill or final status)
// per cycle while there is room, and no new item is taken until it ends.
// Items are buffered in a two-deep input queue and results in a two-deep output
// queue, so either side may stall on its own. Top level; depends on ptlm_pkg,
// ptlm_front and ptlm_back.
module price_time_level_matcher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        push,
   output logic        full,
   input  logic        req_operation,
   input  logic [31:0] req_account,
   input  logic [63:0] req_order_id,
   input  logic [31:0] req_remaining_qty,
   input  logic [31:0] req_visible_qty,
   input  logic [31:0] req_display_qty,
   input  logic [31:0] req_available_qty,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_slot,
   output logic [63:0] rsp_fill_order_id,
   output logic [31:0] rsp_fill_account,
   output logic [31:0] rsp_price,
   output logic [31:0] rsp_quantity,
   output logic        rsp_last
);
   import ptlm_pkg::*;

   logic [31:0] price_ff;
   req_type     push_item, item;
   logic        item_valid, take, rsp_valid;
   rsp_type     rsp;

   // hold level price
   always_ff @(posedge clock) begin
      if (reset) begin
         price_ff <= '0;
      end else if (csr_we) begin
         price_ff <= csr_wdata;
      end
   end

   assign push_item = '{operation: op_type'(req_operation), account: req_account,
                        order_id: req_order_id, remaining_qty: req_remaining_qty,
                        visible_qty: req_visible_qty, display_qty: req_display_qty,
                        available_qty: req_available_qty};

   ptlm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ptlm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .level_price (price_ff),
      .item_valid  (item_valid),
      .item        (item),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp),
      .rsp_take    (pop)
   );

   assign empty             = !rsp_valid;
   assign rsp_kind          = rsp.kind;
   assign rsp_slot          = rsp.slot;
   assign rsp_fill_order_id = rsp.fill_order_id;
   assign rsp_fill_account  = rsp.fill_account;
   assign rsp_price         = rsp.price;
   assign rsp_quantity      = rsp.quantity;
   assign rsp_last          = rsp.last;

`ifndef SYNTHESIS
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != KIND_FILL) |-> (rsp_last && rsp_quantity == 32'd0))
      else $error("status result without last or with quantity");
   a_fill_not_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_FILL) |-> !rsp_last)
      else $error("fill marked last");
   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      take |-> item_valid)
      else $error("engine took from empty input queue");
`endif

endmodule

// ===== rtl/ptlm_front.sv =====
// Front end of the matcher: two-deep input queue that holds accepted items.
// Depends on ptlm_pkg.
module ptlm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ptlm_pkg::req_type push_item,
   output logic             full,
   input  logic             take,
   output logic             item_valid,
   output ptlm_pkg::req_type item
);
   import ptlm_pkg::*;

   req_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_take;

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_take    = take && item_valid;

   // advance pointers and count on each transfer
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_take;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store incoming item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/ptlm_back.sv =====
// Back end of the matcher: resting-order queue, sweep engine and result queue.
// Depends on ptlm_pkg.
module ptlm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      level_price,
   input  logic             item_valid,
   input  ptlm_pkg::req_type item,
   output logic             take,
   output logic             rsp_valid,
   output ptlm_pkg::rsp_type rsp,
   input  logic             rsp_take
);
   import ptlm_pkg::*;

   entry_type         q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [3:0]        loads_ff, loads_in;
   state_type         state_ff, state_in;
   logic [31:0]       acct_ff, acct_in;
   logic [31:0]       avail_ff, avail_in;
   logic [FILL_W-1:0] fills_ff, fills_in;

   rsp_type           oq_ff [2];
   logic              owr_ff, ord_ff;
   logic [1:0]        ocnt_ff, ocnt_in;
   logic              room, emit, do_pop;
   rsp_type           emit_item;

   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   entry_type         wr_data;

   entry_type         h_entry;
   logic [PTR_W-1:0]  tail;
   logic [31:0]       vis_clamp, qty, new_rem, new_vis, refresh;

   assign room      = (ocnt_ff != 2'd2);
   assign do_pop    = rsp_take && rsp_valid;
   assign rsp_valid = (ocnt_ff != 2'd0);
   assign rsp       = oq_ff[ord_ff];

   assign h_entry   = q_ff[head_ff];
   assign tail      = head_ff + count_ff[PTR_W-1:0];
   assign vis_clamp = (item.visible_qty > item.remaining_qty) ? item.remaining_qty
                                                              : item.visible_qty;
   assign qty       = (avail_ff < h_entry.visible) ? avail_ff : h_entry.visible;
   assign new_rem   = h_entry.remaining - qty;
   assign new_vis   = h_entry.visible - qty;
   assign refresh   = (h_entry.display == 32'd0 || h_entry.display > new_rem)
                      ? new_rem : h_entry.display;

   // sequence loads and sweep steps
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      loads_in  = loads_ff;
      acct_in   = acct_ff;
      avail_in  = avail_ff;
      fills_in  = fills_ff;
      take      = 1'b0;
      emit      = 1'b0;
      emit_item = '0;
      wr_en     = 1'b0;
      wr_addr   = tail;
      wr_data   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && room) begin
               take = 1'b1;
               if (item.operation == OP_SWEEP) begin
                  acct_in  = item.account;
                  avail_in = item.available_qty;
                  fills_in = '0;
                  state_in = ST_SWEEP;
               end else if (count_ff >= CNT_W'(QUEUE_DEPTH) || vis_clamp == 32'd0) begin
                  emit           = 1'b1;
                  emit_item.kind = KIND_REJECT;
                  emit_item.last = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = '{slot: loads_ff, account: item.account,
                               id: item.order_id, remaining: item.remaining_qty,
                               visible: vis_clamp, display: item.display_qty};
                  count_in = count_ff + 1'b1;
                  loads_in = loads_ff + 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            if (room) begin
               emit = 1'b1;
               if (avail_ff == 32'd0 || count_ff == '0) begin
                  emit_item.kind = KIND_DONE;
                  emit_item.last = 1'b1;
               end else if (fills_ff == FILL_W'(MAX_FILLS)) begin
                  emit_item.kind = KIND_LIMIT;
                  emit_item.last = 1'b1;
               end else if (h_entry.account == acct_ff) begin
                  emit_item = '{kind: KIND_SELF, slot: h_entry.slot,
                                fill_order_id: h_entry.id,
                                fill_account: h_entry.account,
                                price: level_price, quantity: 32'd0, last: 1'b1};
               end else begin
                  emit_item = '{kind: KIND_FILL, slot: h_entry.slot,
                                fill_order_id: h_entry.id,
                                fill_account: h_entry.account,
                                price: level_price, quantity: qty, last: 1'b0};
                  fills_in = fills_ff + 1'b1;
                  avail_in = avail_ff - qty;
                  if (new_rem == 32'd0) begin
                     head_in  = head_ff + 1'b1;
                     count_in = count_ff - 1'b1;
                  end else if (new_vis == 32'd0) begin
                     // requeue the refreshed iceberg at the back
                     head_in = head_ff + 1'b1;
                     wr_en   = 1'b1;
                     wr_data = '{slot: h_entry.slot, account: h_entry.account,
                                 id: h_entry.id, remaining: new_rem,
                                 visible: refresh, display: h_entry.display};
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = head_ff;
                     wr_data = '{slot: h_entry.slot, account: h_entry.account,
                                 id: h_entry.id, remaining: new_rem,
                                 visible: new_vis, display: h_entry.display};
                  end
               end
               // drop the working queue when the sweep ends
               if (emit_item.last) begin
                  head_in  = '0;
                  count_in = '0;
                  loads_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         loads_ff <= '0;
         fills_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         loads_ff <= loads_in;
         fills_ff <= fills_in;
      end
   end

   always_ff @(posedge clock) begin
      acct_ff  <= acct_in;
      avail_ff <= avail_in;
   end

   // resting-order storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_addr] <= wr_data;
      end
   end

   // result queue
   assign ocnt_in = ocnt_ff + {1'b0, emit} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         owr_ff  <= owr_ff ^ emit;
         ord_ff  <= ord_ff ^ do_pop;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         oq_ff[owr_ff] <= emit_item;
      end
   end

endmodule

// ===== dv/price_time_level_matcher_unit_tb.sv =====
// Self-checking testbench for price_time_level_matcher_unit: drives loads and sweeps,
// predicts the fills of each sweep and checks every result transfer in order.
// Depends on ptlm_pkg and the price_time_level_matcher_unit RTL.
module price_time_level_matcher_unit_tb;
   import ptlm_pkg::*;

   // Level queue mirror and fill predictor; holds the expected results in order.
   class fill_scoreboard;
      rsp_type     pending[$];
      logic [31:0] price_reg;
      entry_type   book[QUEUE_DEPTH];
      int          head_idx;
      int          depth_used;
      int          load_pos;
      int          mismatches;

      function void clear_level();
         head_idx = 0;
         depth_used = 0;
         load_pos = 0;
      endfunction

      function void add(kind_type k, logic [3:0] s, logic [63:0] id, logic [31:0] acct,
                        logic [31:0] pr, logic [31:0] q, logic l);
         rsp_type r;
         r.kind = k;
         r.slot = s;
         r.fill_order_id = id;
         r.fill_account = acct;
         r.price = pr;
         r.quantity = q;
         r.last = l;
         pending.insert(pending.size(), r);
      endfunction

      // Note an accepted input transfer and plan its results.
      function void note_item(req_type rq);
         logic [31:0] vis, avail, q, nv;
         entry_type   e;
         int          fills, h, t;
         kind_type    status;
         if (rq.operation == OP_LOAD) begin
            vis = (rq.visible_qty > rq.remaining_qty) ? rq.remaining_qty : rq.visible_qty;
            if (depth_used >= QUEUE_DEPTH || vis == 0) begin
               add(KIND_REJECT, '0, '0, '0, '0, '0, 1'b1);
               return;
            end
            e.slot = load_pos[3:0];
            e.account = rq.account;
            e.id = rq.order_id;
            e.remaining = rq.remaining_qty;
            e.visible = vis;
            e.display = rq.display_qty;
            book[(head_idx + depth_used) % QUEUE_DEPTH] = e;
            depth_used++;
            load_pos = (load_pos + 1) % 32;
            return;
         end
         avail = rq.available_qty;
         fills = 0;
         status = KIND_DONE;
         while (avail > 0 && depth_used > 0) begin
            h = head_idx;
            if (fills >= MAX_FILLS) begin
               status = KIND_LIMIT;
               break;
            end
            if (book[h].account == rq.account) begin
               add(KIND_SELF, book[h].slot, book[h].id, book[h].account, price_reg, '0, 1'b1);
               status = KIND_SELF;
               break;
            end
            q = (avail < book[h].visible) ? avail : book[h].visible;
            add(KIND_FILL, book[h].slot, book[h].id, book[h].account, price_reg, q, 1'b0);
            fills++;
            book[h].remaining -= q;
            book[h].visible -= q;
            avail -= q;
            if (book[h].remaining == 0) begin
               head_idx = (h + 1) % QUEUE_DEPTH;
               depth_used--;
            end else if (book[h].visible == 0) begin
               // requeue the iceberg at the back with a fresh tranche
               e = book[h];
               nv = (e.display == 0 || e.display > e.remaining) ? e.remaining : e.display;
               e.visible = nv;
               t = (h + depth_used) % QUEUE_DEPTH;
               head_idx = (h + 1) % QUEUE_DEPTH;
               book[t] = e;
            end
         end
         if (status != KIND_SELF) add(status, '0, '0, '0, '0, '0, 1'b1);
         clear_level();
      endfunction

      // Compare one result transfer with the oldest expectation.
      function void check_result(rsp_type got);
         rsp_type exp_r;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %p", got);
            return;
         end
         exp_r = pending[0];
         pending.delete(0);
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        push = 1'b0;
   logic        full;
   logic        req_operation = 1'b0;
   logic [31:0] req_account = '0;
   logic [63:0] req_order_id = '0;
   logic [31:0] req_remaining_qty = '0;
   logic [31:0] req_visible_qty = '0;
   logic [31:0] req_display_qty = '0;
   logic [31:0] req_available_qty = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_kind;
   logic [3:0]  rsp_slot;
   logic [63:0] rsp_fill_order_id;
   logic [31:0] rsp_fill_account;
   logic [31:0] rsp_price;
   logic [31:0] rsp_quantity;
   logic        rsp_last;

   fill_scoreboard sb;
   bit  no_idle = 1'b0;
   bit  hold_pop = 1'b0;
   longint cycles = 0;

   price_time_level_matcher_unit dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .push(push), .full(full), .req_operation(req_operation),
      .req_account(req_account), .req_order_id(req_order_id),
      .req_remaining_qty(req_remaining_qty), .req_visible_qty(req_visible_qty),
      .req_display_qty(req_display_qty), .req_available_qty(req_available_qty),
      .empty(empty), .pop(pop), .rsp_kind(rsp_kind), .rsp_slot(rsp_slot),
      .rsp_fill_order_id(rsp_fill_order_id), .rsp_fill_account(rsp_fill_account),
      .rsp_price(rsp_price), .rsp_quantity(rsp_quantity), .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("price_time_level_matcher_unit_tb NOT OK");
         $finish;
      end
   end

   // Drain results with random stalls; check each transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty)
            sb.check_result('{kind_type'(rsp_kind), rsp_slot, rsp_fill_order_id,
                              rsp_fill_account, rsp_price, rsp_quantity, rsp_last});
         pop <= !hold_pop && (no_idle || $urandom_range(99) >= 11);
      end
   end

   // Offer one item and wait for its transfer; push stays high for the next item.
   task automatic send(req_type rq);
      while (!no_idle && $urandom_range(99) < 11) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_operation <= rq.operation;
      req_account <= rq.account;
      req_order_id <= rq.order_id;
      req_remaining_qty <= rq.remaining_qty;
      req_visible_qty <= rq.visible_qty;
      req_display_qty <= rq.display_qty;
      req_available_qty <= rq.available_qty;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_item(rq);
   endtask

   task automatic load(logic [31:0] acct, logic [63:0] id, logic [31:0] rem,
                       logic [31:0] vis, logic [31:0] disp);
      send('{OP_LOAD, acct, id, rem, vis, disp, $urandom()});
   endtask

   task automatic sweep(logic [31:0] acct, logic [31:0] avail);
      send('{OP_SWEEP, acct, {$urandom(), $urandom()}, $urandom(), $urandom(),
             $urandom(), avail});
   endtask

   // Pause until every expected result has come, then let the engine settle.
   task automatic drain();
      push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_price(logic [31:0] p);
      csr_we <= 1'b1;
      csr_wdata <= p;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.price_reg = p;
   endtask

   // Random order book: mostly well-formed loads followed by a sweep.
   task automatic random_book();
      int n;
      logic [31:0] a;
      n = $urandom_range(18);
      for (int i = 0; i < n; i++) begin
         a = $urandom_range(3) == 0 ? $urandom() : $urandom_range(5);
         case ($urandom_range(4))
            0: load(a, {$urandom(), $urandom()}, $urandom(), $urandom(), $urandom());
            1: load(a, {$urandom(), $urandom()}, $urandom_range(20), $urandom_range(20), 0);
            default: load(a, {$urandom(), $urandom()}, $urandom_range(1, 60),
                          $urandom_range(0, 12), $urandom_range(0, 8));
         endcase
      end
      case ($urandom_range(3))
         0: sweep($urandom_range(5), $urandom());
         1: sweep($urandom(), 32'hFFFFFFFF);
         default: sweep($urandom_range(9), $urandom_range(0, 200));
      endcase
   endtask

   int sent;

   initial begin
      sb = new();
      sb.price_reg = '0;
      sb.clear_level();
      sb.mismatches = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      sweep(1, 100);                                   // empty queue
      load(7, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      load(8, 1, 10, 0, 5);                            // zero visible rejected
      load(8, 2, 0, 9, 5);                             // zero remaining rejected
      load(9, 3, 10, 20, 0);                           // visible clamped
      sweep(32'hFFFFFFFF, 0);                          // zero available
      drain();
      set_price(32'hFFFFFFFF);
      load(2, 10, 30, 4, 0);                           // iceberg, zero display
      load(3, 11, 9, 2, 3);
      load(4, 12, 5, 5, 1);
      sweep(5, 32'hFFFFFFFF);
      load(1, 20, 5, 5, 0);
      load(6, 21, 5, 5, 0);
      sweep(6, 8);                                     // self match on second
      for (int i = 0; i < 17; i++) load(32'(i + 100), 64'(i), 100, 1, 1); // overflow
      sweep(0, 32'hFFFFFFFF);                          // hits the fill limit
      drain();
      set_price(32'h0);

      // Random part with pressure phases.
      sent = 0;
      while (sent < 270) begin
         if (sent > 60 && sent < 120) no_idle = 1'b1;
         else no_idle = 1'b0;
         if (sent > 150 && sent < 170) begin
            fork
               begin
                  hold_pop = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_pop = 1'b0;
               end
               begin
                  random_book();
                  random_book();
               end
            join
            sent += 20;
            drain();
            set_price($urandom());
         end else begin
            random_book();
            sent += 10;
         end
      end
      drain();

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("price_time_level_matcher_unit_tb OK");
      else
         $display("price_time_level_matcher_unit_tb NOT OK");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/ptlm_pkg.sv
rtl/ptlm_front.sv
rtl/ptlm_back.sv
rtl/price_time_level_matcher_unit.sv
dv/price_time_level_matcher_unit_tb.sv
